>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mch_pkg.sv
// ---------------------------------------------------------------------------
// Compass heading package
// Widths, reset values, sequencer states and the CORDIC angle table.
// ---------------------------------------------------------------------------
package mch_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int COEF_FRAC_BITS    = 12;
  localparam int CORDIC_ITERATIONS = 16;

  localparam int COEF_BITS = COEF_FRAC_BITS + 4;
  localparam int ROW_BITS  = 3 * COEF_BITS;
  localparam int BIAS_BITS = SAMPLE_BITS + 1;
  localparam int V_BITS    = SAMPLE_BITS + 2;
  localparam int PROD_BITS = COEF_BITS + V_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int CORD_BITS = ACC_BITS + 4;
  localparam int ANG_BITS  = 32;
  localparam int DECL_BITS = 17;
  localparam int PER_BITS  = 8;
  localparam int HDG_BITS  = 9;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = ROW_BITS;
  localparam int ITER_BITS = $clog2(CORDIC_ITERATIONS);
  localparam int ATAN_LEN  = 24;
  localparam int ATAN_IDX_BITS = $clog2(ATAN_LEN);
  localparam int MAC_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECL   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD = 3'd4;

  localparam logic [ROW_BITS-1:0]  ROW_X_RST  = 48'd4096;
  localparam logic [ROW_BITS-1:0]  ROW_Y_RST  = 48'd268435456;
  localparam logic [ROW_BITS-1:0]  ROW_Z_RST  = 48'd17592186044416;
  localparam logic [DECL_BITS-1:0] DECL_RST   = 17'd3264;
  localparam logic [PER_BITS-1:0]  PERIOD_RST = 8'd20;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic signed [ANG_BITS-1:0] DEG_HALF = 32'sd32768;
  localparam logic signed [ANG_BITS-1:0] DEG_90   = 32'sd5898240;
  localparam logic signed [ANG_BITS-1:0] DEG_180  = 32'sd11796480;
  localparam logic signed [ANG_BITS-1:0] DEG_360  = 32'sd23592960;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_VEC,
    S_MAC,
    S_CORD,
    S_FIN,
    S_WRAP
  } state_t;

  function automatic logic signed [ANG_BITS-1:0] atan_q16(input logic [ATAN_IDX_BITS-1:0] i);
    logic signed [ANG_BITS-1:0] a;
    case (i)
      5'd0:  a = 32'sd2949120;
      5'd1:  a = 32'sd1740967;
      5'd2:  a = 32'sd919879;
      5'd3:  a = 32'sd466945;
      5'd4:  a = 32'sd234379;
      5'd5:  a = 32'sd117304;
      5'd6:  a = 32'sd58666;
      5'd7:  a = 32'sd29335;
      5'd8:  a = 32'sd14668;
      5'd9:  a = 32'sd7334;
      5'd10: a = 32'sd3667;
      5'd11: a = 32'sd1833;
      5'd12: a = 32'sd917;
      5'd13: a = 32'sd458;
      5'd14: a = 32'sd229;
      5'd15: a = 32'sd115;
      5'd16: a = 32'sd57;
      5'd17: a = 32'sd29;
      5'd18: a = 32'sd14;
      5'd19: a = 32'sd7;
      5'd20: a = 32'sd4;
      5'd21: a = 32'sd2;
      5'd22: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> hw/rtl/mch_if.sv
// ---------------------------------------------------------------------------
// Compass heading channels
// Valid/ready channels for samples, headings and register writes.
// ---------------------------------------------------------------------------
interface mch_in_if import mch_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic signed [SAMPLE_BITS-1:0] mag_z;
  modport source (output valid, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, mag_x, mag_y, mag_z, output ready);
endinterface

interface mch_out_if import mch_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HDG_BITS-1:0] heading_deg;
  modport source (output valid, heading_deg, input ready);
  modport sink   (input valid, heading_deg, output ready);
endinterface

interface mch_cfg_if import mch_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/mch_cordic.sv
// ---------------------------------------------------------------------------
// Iterative CORDIC atan2
// One shift-add stage reused per iteration; angle in 2^-16 degree units.
// ---------------------------------------------------------------------------
module mch_cordic import mch_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [CORD_BITS-1:0] x_in,
  input  logic signed [CORD_BITS-1:0] y_in,
  output logic                        done,
  output logic signed [ANG_BITS-1:0]  z_out
);

  logic signed [CORD_BITS-1:0] x_r, y_r, xs, ys;
  logic signed [ANG_BITS-1:0]  z_r;
  logic [ITER_BITS-1:0]        it_r;
  logic                        run_r, done_r, zero_r;

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        zero_r <= (x_in == '0) && (y_in == '0);
        it_r   <= '0;
        run_r  <= 1'b1;
        if (x_in < 0) begin
          x_r <= -x_in;
          y_r <= -y_in;
          z_r <= (y_in >= 0) ? DEG_180 : -DEG_180;
        end else begin
          x_r <= x_in;
          y_r <= y_in;
          z_r <= '0;
        end
      end else if (run_r) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_q16(ATAN_IDX_BITS'(it_r));
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_q16(ATAN_IDX_BITS'(it_r));
        end
        it_r <= it_r + 1'b1;
        if (it_r == ITER_BITS'(CORDIC_ITERATIONS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign z_out = zero_r ? '0 : z_r;

endmodule

>>> hw/rtl/magnetometer_compass_heading.sv
// ---------------------------------------------------------------------------
// Calibrated compass heading
// Samples are accepted only in idle, so a new one waits until the previous
// heading is loaded into the output register, behind any output stall.
// Steps: update, vector, multiply-accumulate of six products, 16-iteration
// CORDIC, declination, and a wrap step repeated while the angle leaves 0..360.
// Reset: config registers to identity matrix, 12.75 deg, period 20;
// min/max tracking, bias and sample count cleared at once.
// ---------------------------------------------------------------------------
module magnetometer_compass_heading import mch_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mch_in_if.sink    in_if,
  mch_out_if.source out_if,
  mch_cfg_if.sink   cfg_if
);

  state_t state_r, state_nxt;

  logic [ROW_BITS-1:0]         row_x_r, row_y_r, row_z_r;
  logic signed [DECL_BITS-1:0] decl_r;
  logic [PER_BITS-1:0]         period_r;

  logic signed [SAMPLE_BITS-1:0] s_r   [3];
  logic signed [SAMPLE_BITS-1:0] max_r [3];
  logic signed [SAMPLE_BITS-1:0] min_r [3];
  logic signed [SAMPLE_BITS-1:0] max_nxt [3];
  logic signed [SAMPLE_BITS-1:0] min_nxt [3];
  logic signed [BIAS_BITS-1:0]   bias_r [3];
  logic signed [V_BITS-1:0]      v_r   [3];
  logic [PER_BITS-1:0]           count_r, count_inc;

  logic [MAC_IDX_BITS-1:0]       idx_r;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [V_BITS-1:0]      v_sel;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [ACC_BITS-1:0]    acc_x_r, acc_y_r;

  logic                          cord_start, cord_done;
  logic signed [ANG_BITS-1:0]    cord_z, deg_r, deg_rnd;

  logic                          out_valid_r;
  logic [HDG_BITS-1:0]           heading_r;
  logic                          out_free;

  assign in_if.ready    = (state_r == S_IDLE);
  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.heading_deg = heading_r;
  assign out_free       = !out_valid_r || out_if.ready;
  assign count_inc      = count_r + 1'b1;
  assign deg_rnd        = deg_r + DEG_HALF;
  assign cord_start     = (state_r == S_MAC) && (idx_r == MAC_IDX_BITS'(7));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      max_nxt[i] = (s_r[i] > max_r[i]) ? s_r[i] : max_r[i];
      min_nxt[i] = (s_r[i] < min_r[i]) ? s_r[i] : min_r[i];
    end
  end

  always_comb begin
    case (idx_r)
      3'd0:    coef = row_x_r[0*COEF_BITS +: COEF_BITS];
      3'd1:    coef = row_x_r[1*COEF_BITS +: COEF_BITS];
      3'd2:    coef = row_x_r[2*COEF_BITS +: COEF_BITS];
      3'd3:    coef = row_y_r[0*COEF_BITS +: COEF_BITS];
      3'd4:    coef = row_y_r[1*COEF_BITS +: COEF_BITS];
      3'd5:    coef = row_y_r[2*COEF_BITS +: COEF_BITS];
      default: coef = '0;
    endcase
    case (idx_r)
      3'd0, 3'd3: v_sel = v_r[0];
      3'd1, 3'd4: v_sel = v_r[1];
      3'd2, 3'd5: v_sel = v_r[2];
      default:    v_sel = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_if.valid) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_VEC;
      S_VEC:  state_nxt = S_MAC;
      S_MAC:  if (cord_start) state_nxt = S_CORD;
      S_CORD: if (cord_done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_WRAP;
      S_WRAP: begin
        if (deg_r >= 0 && deg_r <= DEG_360 && out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_x_r     <= ROW_X_RST;
      row_y_r     <= ROW_Y_RST;
      row_z_r     <= ROW_Z_RST;
      decl_r      <= DECL_RST;
      period_r    <= PERIOD_RST;
      count_r     <= '0;
      idx_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        max_r[i]  <= SAMPLE_MIN;
        min_r[i]  <= SAMPLE_MAX;
        bias_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_if.valid) begin
        case (cfg_if.index)
          REG_ROW_X:  row_x_r  <= cfg_if.data;
          REG_ROW_Y:  row_y_r  <= cfg_if.data;
          REG_ROW_Z:  row_z_r  <= cfg_if.data;
          REG_DECL:   decl_r   <= cfg_if.data[DECL_BITS-1:0];
          REG_PERIOD: period_r <= cfg_if.data[PER_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            s_r[0] <= in_if.mag_x;
            s_r[1] <= in_if.mag_y;
            s_r[2] <= in_if.mag_z;
          end
        end
        S_UPD: begin
          for (int i = 0; i < 3; i++) begin
            max_r[i] <= max_nxt[i];
            min_r[i] <= min_nxt[i];
          end
          if (count_inc > period_r) begin
            count_r <= '0;
            for (int i = 0; i < 3; i++) begin
              if (min_nxt[i] < max_nxt[i])
                bias_r[i] <= BIAS_BITS'(max_nxt[i]) + BIAS_BITS'(min_nxt[i]);
            end
          end else begin
            count_r <= count_inc;
          end
        end
        S_VEC: begin
          for (int i = 0; i < 3; i++)
            v_r[i] <= (V_BITS'(s_r[i]) <<< 1) - V_BITS'(bias_r[i]);
          acc_x_r <= '0;
          acc_y_r <= '0;
          idx_r   <= '0;
        end
        S_MAC: begin
          prod_r <= PROD_BITS'(coef) * PROD_BITS'(v_sel);
          if (idx_r >= MAC_IDX_BITS'(1) && idx_r <= MAC_IDX_BITS'(3))
            acc_x_r <= acc_x_r + ACC_BITS'(prod_r);
          else if (idx_r >= MAC_IDX_BITS'(4) && idx_r <= MAC_IDX_BITS'(6))
            acc_y_r <= acc_y_r + ACC_BITS'(prod_r);
          idx_r <= idx_r + 1'b1;
        end
        S_CORD: begin
          if (cord_done) deg_r <= cord_z;
        end
        S_FIN: begin
          deg_r <= deg_r + (ANG_BITS'(decl_r) <<< 8) + DEG_90;
        end
        S_WRAP: begin
          if (deg_r < 0) begin
            deg_r <= deg_r + DEG_360;
          end else if (deg_r > DEG_360) begin
            deg_r <= deg_r - DEG_360;
          end else if (out_free) begin
            heading_r   <= deg_rnd[16 +: HDG_BITS];
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  mch_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x_in  (CORD_BITS'(acc_x_r)),
    .y_in  (CORD_BITS'(acc_y_r)),
    .done  (cord_done),
    .z_out (cord_z)
  );

`include "assert_macros.svh"

  `MCH_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_if.ready, state_r == S_UPD, "no update")
  `MCH_ASSERT_NOW(a_heading_range, out_if.valid, out_if.heading_deg <= 9'd360, "heading above 360")
  `MCH_ASSERT_NOW(a_cordic_done_wait, cord_done, state_r == S_CORD, "CORDIC done early")

endmodule

>>> sim/magnetometer_compass_heading_tb.sv
// ---------------------------------------------------------------------------
// Compass heading testbench
// Drives magnetometer samples and register writes through the valid/ready
// channels, predicts each heading from tracked min/max, bias, soft-iron
// matrix and CORDIC, and checks every heading transaction in order.
// ---------------------------------------------------------------------------
module magnetometer_compass_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mch_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mch_in_if  in_ch ();
  mch_out_if out_ch ();
  mch_cfg_if cfg_ch ();

  magnetometer_compass_heading dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [ROW_BITS-1:0]  row_x, row_y, row_z;
  logic [DECL_BITS-1:0] decl_q8;
  logic [PER_BITS-1:0]  period;
  int                   trk_max[3], trk_min[3], twice_bias[3];
  int unsigned          samp_cnt;

  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  logic [HDG_BITS-1:0] heading_q[$];
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int stalled_cyc = 0;

  function automatic longint row_sum(logic [ROW_BITS-1:0] row, longint v[3]);
    longint acc;
    acc = 0;
    for (int j = 0; j < 3; j++) begin
      acc += longint'($signed(row[j*COEF_BITS +: COEF_BITS])) * v[j];
    end
    return acc;
  endfunction

  function automatic logic [HDG_BITS-1:0] predict_heading(logic signed [15:0] mx,
                                                          logic signed [15:0] my,
                                                          logic signed [15:0] mz);
    int     s[3];
    longint v[3];
    longint x, y, ang, xs, ys, deg;
    s[0] = mx;
    s[1] = my;
    s[2] = mz;
    for (int i = 0; i < 3; i++) begin
      if (s[i] > trk_max[i]) trk_max[i] = s[i];
      if (s[i] < trk_min[i]) trk_min[i] = s[i];
    end
    samp_cnt = (samp_cnt + 1) & 8'hFF;
    if (samp_cnt > period) begin
      for (int i = 0; i < 3; i++) begin
        if (trk_min[i] < trk_max[i]) twice_bias[i] = trk_max[i] + trk_min[i];
      end
      samp_cnt = 0;
    end
    for (int i = 0; i < 3; i++) v[i] = 2 * longint'(s[i]) - twice_bias[i];
    x = row_sum(row_x, v);
    y = row_sum(row_y, v);
    ang = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          ang += atan_tab[i];
        end else begin
          x = x - ys;
          y = y + xs;
          ang -= atan_tab[i];
        end
      end
    end
    deg = ang + longint'($signed(decl_q8)) * 256 + 90 * 65536;
    while (deg < 0) deg += 360 * 65536;
    while (deg > 360 * 65536) deg -= 360 * 65536;
    return HDG_BITS'((deg + 32768) >>> 16);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // heading checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (heading_q.size() == 0) begin
        report_mismatch("unexpected heading", out_ch.heading_deg, -1);
      end else begin
        if (out_ch.heading_deg !== heading_q[0])
          report_mismatch("heading_deg", out_ch.heading_deg, heading_q[0]);
        void'(heading_q.pop_front());
        n_checked++;
      end
    end
  end

  // heading receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stalled_cyc <= 0;
    end else begin
      stalled_cyc <= stalled_cyc + 1;
      if (stalled_cyc >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d headings pending", heading_q.size());
        $display("magnetometer_compass_heading: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [15:0] mx, logic signed [15:0] my,
                             logic signed [15:0] mz);
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mag_x <= mx;
    in_ch.mag_y <= my;
    in_ch.mag_z <= mz;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    heading_q.push_back(predict_heading(mx, my, mz));
    n_items++;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (heading_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      REG_ROW_X:  row_x = data;
      REG_ROW_Y:  row_y = data;
      REG_ROW_Z:  row_z = data;
      REG_DECL:   decl_q8 = data[DECL_BITS-1:0];
      REG_PERIOD: period = data[PER_BITS-1:0];
      default: ;
    endcase
    n_cfg++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_matrix(logic [ROW_BITS-1:0] rx, logic [ROW_BITS-1:0] ry,
                              logic [ROW_BITS-1:0] rz);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
  endtask

  task automatic send_random(int centre[3], int spread);
    logic signed [15:0] f[3];
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < 25) begin
        f[i] = 16'($urandom);
      end else begin
        f[i] = 16'(centre[i] + $signed($urandom_range(2 * spread)) - spread);
      end
    end
    send_sample(f[0], f[1], f[2]);
  endtask

  task automatic test_directed;
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd100, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd100, 16'sd0);
    send_sample(-16'sd100, 16'sd0, 16'sd0);
    send_sample(-16'sd100, -16'sd1, 16'sd0);
    send_sample(16'sd0, -16'sd100, 16'sd0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 16'sd0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, 16'sd0);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd1, -16'sd1, 16'sd1);
    send_sample(16'sd3000, 16'sd3000, 16'sd5);
    send_sample(-16'sd3000, 16'sd3000, -16'sd5);
    for (int i = 0; i < 10; i++)
      send_sample(16'sd50, 16'sd20, 16'sd7);
    drain();
  endtask

  task automatic test_config_extremes;
    int c[3];
    c = '{0, 0, 0};
    // identity matrix and extreme declinations, short period
    write_reg(REG_PERIOD, 0);
    write_reg(REG_DECL, 48'(-46080));
    write_matrix({16'sd0, 16'sd0, 16'sd4096}, {16'sd0, 16'sd4096, 16'sd0},
                 {16'sd4096, 16'sd0, 16'sd0});
    for (int i = 0; i < 40; i++) send_random(c, 2000);
    drain();
    write_reg(REG_DECL, 48'd46080);
    write_reg(REG_PERIOD, 1);
    write_matrix({16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF},
                 {16'hFFFF, 16'h0001, 16'h8000});
    for (int i = 0; i < 40; i++) send_random(c, 30000);
    drain();
    // out-of-range declination and a period that never recomputes
    write_reg(REG_DECL, 48'h10000);
    write_reg(REG_PERIOD, 255);
    write_reg(3'd5, '1);
    write_reg(3'd7, 48'h123456789ABC);
    for (int i = 0; i < 40; i++) send_random(c, 30000);
    drain();
    write_reg(REG_DECL, 48'h0FFFF);
    write_reg(REG_PERIOD, 3);
    write_matrix('1, '0, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 30; i++) send_random(c, 500);
    drain();
    write_matrix(ROW_X_RST, ROW_Y_RST, ROW_Z_RST);
    write_reg(REG_DECL, DECL_RST);
    write_reg(REG_PERIOD, PERIOD_RST);
    for (int i = 0; i < 30; i++) send_random(c, 8000);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    int c[3];
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 150 == 0) begin
        drain();
        if ($urandom_range(2) == 0) begin
          write_matrix(ROW_X_RST, ROW_Y_RST, ROW_Z_RST);
        end else begin
          write_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        end
        write_reg(REG_DECL, 48'($signed($urandom_range(92160)) - 46080));
        write_reg(REG_PERIOD, $urandom_range(255));
        for (int i = 0; i < 3; i++) c[i] = $signed($urandom_range(40000)) - 20000;
      end
      send_random(c, $urandom_range(1, 12000));
    end
    drain();
  endtask

  task automatic test_backpressure;
    int c[3];
    c = '{100, -200, 300};
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_random(c, 4000);
    drain();
    for (int i = 0; i < 20; i++) send_random(c, 4000);
    drain();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.mag_x  = '0;
    in_ch.mag_y  = '0;
    in_ch.mag_z  = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    row_x = ROW_X_RST;
    row_y = ROW_Y_RST;
    row_z = ROW_Z_RST;
    decl_q8 = DECL_RST;
    period = PERIOD_RST;
    for (int i = 0; i < 3; i++) begin
      trk_max[i] = -32768;
      trk_min[i] = 32767;
      twice_bias[i] = 0;
    end
    samp_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_phase(450, 20, 71);
    test_random_phase(450, 71, 20);
    test_random_phase(450, 0, 0);
    test_backpressure();

    $display("covered %0d samples, %0d headings checked, %0d register writes",
             n_items, n_checked, n_cfg);
    $display("including extreme declinations, periods 0/1/255, long output hold");
    if (errors == 0) begin
      $display("magnetometer_compass_heading: match");
    end else begin
      $display("magnetometer_compass_heading: mismatch");
    end
    $finish;
  end

endmodule
